[sv/affine_matrix_compose_invert_macros.svh]
// Assertion macros used by the affine matrix unit checker.
`ifndef AFFINE_MATRIX_COMPOSE_INVERT_MACROS_SVH
`define AFFINE_MATRIX_COMPOSE_INVERT_MACROS_SVH
// Same-cycle implication, clocked on clk, off while rst_n is low.
`define AMCI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amci same-cycle check failed");
// Next-cycle implication, clocked on clk, off while rst_n is low.
`define AMCI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amci next-cycle check failed");
`endif

[sv/amci_pkg.sv]
// Shared constants, types and helpers of the affine matrix unit.
package amci_pkg;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int DATA_W   = 32;
    localparam int THR_W    = 17;
    localparam int IDX_W    = 3;
    localparam int ACC_W    = 66;
    localparam int MAG_W    = 64;
    localparam int QUO_BITS = 33;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_COMPOSE = 2'd1;
    localparam logic [1:0] REQ_INVERT  = 2'd2;
    localparam logic [1:0] REQ_NOP     = 2'd3;

    localparam logic [IDX_W-1:0] IDX_A  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_B  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_C  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_D  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_TX = 3'd4;
    localparam logic [IDX_W-1:0] IDX_TY = 3'd5;

    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_SET  = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    localparam logic [1:0] CUR_HOLD       = 2'd0;
    localparam logic [1:0] CUR_LOAD_IN    = 2'd1;
    localparam logic [1:0] CUR_LOAD_RES   = 2'd2;
    localparam logic [1:0] CUR_LOAD_IDENT = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] tx;
        logic signed [DATA_W-1:0] ty;
    } mat_t;

    typedef struct packed {
        logic             in_we;
        logic             flags_clr;
        logic             mul_en;
        logic [IDX_W-1:0] mx_sel;
        logic [IDX_W-1:0] my_sel;
        logic             my_cur;
        logic [1:0]       acc_op;
        logic             base_half;
        logic             base_w;
        logic [IDX_W-1:0] w_sel;
        logic             det_we;
        logic             div_start;
        logic             div_num_acc;
        logic [IDX_W-1:0] div_num_sel;
        logic             div_flip;
        logic             div_wide;
        logic             res_we;
        logic             res_div;
        logic [IDX_W-1:0] res_sel;
        logic [1:0]       cur_op;
        logic             out_we;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic det_singular;
    } status_t;

    function automatic logic signed [DATA_W-1:0] mat_pick(input mat_t m,
                                                          input logic [IDX_W-1:0] idx);
        logic signed [DATA_W-1:0] v;
        case (idx)
            IDX_A:   v = m.a;
            IDX_B:   v = m.b;
            IDX_C:   v = m.c;
            IDX_D:   v = m.d;
            IDX_TX:  v = m.tx;
            IDX_TY:  v = m.ty;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

[sv/amci_channels.sv]
// Handshake channel interfaces of the affine matrix unit.
interface amci_cfg_if import amci_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] singular_threshold;
    modport source (output valid, output singular_threshold, input ready);
    modport sink (input valid, input singular_threshold, output ready);
endinterface

interface amci_req_if import amci_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] in_a;
    logic signed [DATA_W-1:0] in_b;
    logic signed [DATA_W-1:0] in_c;
    logic signed [DATA_W-1:0] in_d;
    logic signed [DATA_W-1:0] in_tx;
    logic signed [DATA_W-1:0] in_ty;
    modport source (output valid, output req_type, output in_a, output in_b, output in_c,
                    output in_d, output in_tx, output in_ty, input ready);
    modport sink (input valid, input req_type, input in_a, input in_b, input in_c,
                  input in_d, input in_tx, input in_ty, output ready);
endinterface

interface amci_rsp_if import amci_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_a;
    logic signed [DATA_W-1:0] out_b;
    logic signed [DATA_W-1:0] out_c;
    logic signed [DATA_W-1:0] out_d;
    logic signed [DATA_W-1:0] out_tx;
    logic signed [DATA_W-1:0] out_ty;
    logic                     singular;
    logic                     is_identity;
    logic                     saturated;
    modport source (output valid, output out_a, output out_b, output out_c, output out_d,
                    output out_tx, output out_ty, output singular, output is_identity,
                    output saturated, input ready);
    modport sink (input valid, input out_a, input out_b, input out_c, input out_d,
                  input out_tx, input out_ty, input singular, input is_identity,
                  input saturated, output ready);
endinterface

[sv/amci_div.sv]
// Restoring divider with overflow check and round-half-away, clamped to 32 bits.
module amci_div import amci_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [MAG_W+2*FRAC_BITS-1:0]  numer,
    input  logic [MAG_W-1:0]              denom,
    input  logic                          neg,
    output logic                          done,
    output logic signed [DATA_W-1:0]      quo,
    output logic                          sat
);
    localparam int NW    = MAG_W + 2*FRAC_BITS;
    localparam int HI_W  = NW - QUO_BITS;
    localparam int CMP_W = (HI_W > MAG_W) ? HI_W : MAG_W;
    localparam int CNT_W = $clog2(QUO_BITS);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;
    localparam logic [1:0] D_FIN  = 2'd3;

    localparam logic [QUO_BITS:0] NEG_LIM = (QUO_BITS+1)'(64'd1 << (DATA_W-1));
    localparam logic [QUO_BITS:0] POS_LIM = (QUO_BITS+1)'((64'd1 << (DATA_W-1)) - 64'd1);

    logic [1:0]              st_reg, st_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [NW-1:0]           n_reg;
    logic [MAG_W-1:0]        d_reg;
    logic                    neg_reg;
    logic                    ovf_reg;
    logic [MAG_W-1:0]        rem_reg;
    logic [QUO_BITS-1:0]     lo_reg;
    logic [QUO_BITS-1:0]     q_reg;
    logic signed [DATA_W-1:0] quo_reg;
    logic                    sat_reg;

    logic [HI_W-1:0]   hi;
    logic              ovf_c;
    logic [MAG_W:0]    trial;
    logic              ge;
    logic [MAG_W:0]    trial_sub;
    logic              round_up;
    logic [QUO_BITS:0] qr;

    always_comb
    begin
        hi        = n_reg[NW-1:QUO_BITS];
        ovf_c     = CMP_W'(hi) >= CMP_W'(d_reg);
        trial     = {rem_reg, lo_reg[QUO_BITS-1]};
        ge        = trial >= {1'b0, d_reg};
        trial_sub = trial - {1'b0, d_reg};
        round_up  = {rem_reg, 1'b0} >= {1'b0, d_reg};
        qr        = {1'b0, q_reg} + {{QUO_BITS{1'b0}}, round_up};
    end

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (st_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    st_next = D_CHK;
                end
            end
            D_CHK:
            begin
                cnt_next = '0;
                st_next  = ovf_c ? D_FIN : D_RUN;
            end
            D_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_BITS-1))
                begin
                    st_next = D_FIN;
                end
            end
            D_FIN:
            begin
                done_next = 1'b1;
                st_next   = D_IDLE;
            end
            default:
            begin
                st_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == D_IDLE && start)
        begin
            n_reg   <= numer;
            d_reg   <= denom;
            neg_reg <= neg;
        end
        if (st_reg == D_CHK)
        begin
            ovf_reg <= ovf_c;
            rem_reg <= MAG_W'(hi);
            lo_reg  <= n_reg[QUO_BITS-1:0];
            q_reg   <= '0;
        end
        if (st_reg == D_RUN)
        begin
            rem_reg <= ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
            lo_reg  <= {lo_reg[QUO_BITS-2:0], 1'b0};
            q_reg   <= {q_reg[QUO_BITS-2:0], ge};
        end
        if (st_reg == D_FIN)
        begin
            if (neg_reg)
            begin
                sat_reg <= ovf_reg || (qr > NEG_LIM);
                quo_reg <= (ovf_reg || (qr > NEG_LIM)) ? {1'b1, {(DATA_W-1){1'b0}}}
                                                       : DATA_W'(~qr[DATA_W-1:0] + 1'b1);
            end
            else
            begin
                sat_reg <= ovf_reg || (qr > POS_LIM);
                quo_reg <= (ovf_reg || (qr > POS_LIM)) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                       : qr[DATA_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign sat  = sat_reg;
endmodule

[sv/amci_dp.sv]
// Datapath: matrix registers, shared multiplier, accumulator, rounding and divider.
module amci_dp import amci_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_data,
    input  mat_t             in_mat,
    input  cmd_t             cmd,
    output status_t          status,
    output mat_t             out_mat,
    output logic             out_singular,
    output logic             out_is_identity,
    output logic             out_saturated
);
    localparam int NW = MAG_W + 2*FRAC_BITS;
    localparam logic signed [DATA_W-1:0] ONE  = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0]  HALF = ACC_W'(64'd1 << (FRAC_BITS-1));

    logic [THR_W-1:0]         thr_reg;
    mat_t                     cur_reg, cur_next;
    mat_t                     op_reg;
    mat_t                     res_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [MAG_W-1:0]         dm_reg;
    logic                     dn_reg;
    logic                     sing_det_reg;
    logic                     sat_reg;
    logic                     sing_reg;
    mat_t                     out_mat_reg;
    logic                     out_sing_reg;
    logic                     out_ident_reg;
    logic                     out_sat_reg;

    logic signed [DATA_W-1:0] mx, my, w, src;
    logic signed [ACC_W-1:0]  prod_ext, base, q_full;
    logic [ACC_W-1:0]         acc_abs;
    logic                     acc_neg;
    logic [MAG_W-1:0]         acc_mag, thr_shift, num;
    logic                     det_sing;
    logic [ACC_W-DATA_W:0]    upper;
    logic                     inrange;
    logic signed [DATA_W-1:0] cmp_val, res_val;
    logic                     res_sat;
    logic                     src_neg, div_neg;
    logic signed [DATA_W:0]   src_ext;
    logic [DATA_W:0]          src_mag;
    logic [NW-1:0]            numer;
    logic                     div_done, div_sat;
    logic signed [DATA_W-1:0] div_quo;
    logic                     cur_ident;

    always_comb
    begin
        mx       = mat_pick(cur_reg, cmd.mx_sel);
        my       = cmd.my_cur ? mat_pick(cur_reg, cmd.my_sel) : mat_pick(op_reg, cmd.my_sel);
        w        = mat_pick(cur_reg, cmd.w_sel);
        prod_ext = {{(ACC_W-2*DATA_W){prod_reg[2*DATA_W-1]}}, prod_reg};
        base     = (cmd.base_half ? HALF : '0)
                 + (cmd.base_w ? ({{(ACC_W-DATA_W){w[DATA_W-1]}}, w} <<< FRAC_BITS) : '0);
        case (cmd.acc_op)
            ACC_SET:  acc_next = base + prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase

        acc_neg   = acc_reg[ACC_W-1];
        acc_abs   = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        acc_mag   = acc_abs[MAG_W-1:0];
        thr_shift = MAG_W'(thr_reg) << FRAC_BITS;
        det_sing  = (acc_mag == '0) || (acc_mag < thr_shift);

        // round-to-nearest result of compose: bias is already in the accumulator
        q_full  = acc_reg >>> FRAC_BITS;
        upper   = q_full[ACC_W-1:DATA_W-1];
        inrange = (&upper) || (~|upper);
        cmp_val = inrange ? q_full[DATA_W-1:0]
                          : (q_full[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                             : {1'b0, {(DATA_W-1){1'b1}}});

        src     = mat_pick(cur_reg, cmd.div_num_sel);
        src_neg = src[DATA_W-1];
        src_ext = {src[DATA_W-1], src};
        src_mag = src_neg ? (DATA_W+1)'(-src_ext) : (DATA_W+1)'(src_ext);
        num     = cmd.div_num_acc ? acc_mag : MAG_W'(src_mag);
        div_neg = (cmd.div_num_acc ? acc_neg : src_neg) ^ cmd.div_flip ^ dn_reg;
        numer   = cmd.div_wide ? (NW'(num) << (2*FRAC_BITS)) : (NW'(num) << FRAC_BITS);

        res_val = cmd.res_div ? div_quo : cmp_val;
        res_sat = cmd.res_div ? div_sat : !inrange;

        case (cmd.cur_op)
            CUR_LOAD_IN:    cur_next = op_reg;
            CUR_LOAD_RES:   cur_next = res_reg;
            CUR_LOAD_IDENT: cur_next = '{a: ONE, b: '0, c: '0, d: ONE, tx: '0, ty: '0};
            default:        cur_next = cur_reg;
        endcase

        cur_ident = (cur_reg.a == ONE) && (cur_reg.b == '0) && (cur_reg.c == '0)
                 && (cur_reg.d == ONE) && (cur_reg.tx == '0) && (cur_reg.ty == '0);
    end

    amci_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (numer),
        .denom (dm_reg),
        .neg   (div_neg),
        .done  (div_done),
        .quo   (div_quo),
        .sat   (div_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_W'(1);
            cur_reg  <= '{a: ONE, b: '0, c: '0, d: ONE, tx: '0, ty: '0};
            sat_reg  <= 1'b0;
            sing_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            cur_reg <= cur_next;
            if (cmd.flags_clr)
            begin
                sat_reg  <= 1'b0;
                sing_reg <= 1'b0;
            end
            else
            begin
                if (cmd.res_we && res_sat)
                begin
                    sat_reg <= 1'b1;
                end
                if (cmd.cur_op == CUR_LOAD_IDENT)
                begin
                    sing_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_we)
        begin
            op_reg <= in_mat;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mx * my;
        end
        acc_reg <= acc_next;
        if (cmd.det_we)
        begin
            dm_reg       <= acc_mag;
            dn_reg       <= acc_neg;
            sing_det_reg <= det_sing;
        end
        if (cmd.res_we)
        begin
            case (cmd.res_sel)
                IDX_A:   res_reg.a  <= res_val;
                IDX_B:   res_reg.b  <= res_val;
                IDX_C:   res_reg.c  <= res_val;
                IDX_D:   res_reg.d  <= res_val;
                IDX_TX:  res_reg.tx <= res_val;
                default: res_reg.ty <= res_val;
            endcase
        end
        if (cmd.out_we)
        begin
            out_mat_reg   <= cur_reg;
            out_sing_reg  <= sing_reg;
            out_ident_reg <= cur_ident;
            out_sat_reg   <= sat_reg;
        end
    end

    assign status.div_done     = div_done;
    assign status.det_singular = sing_det_reg;
    assign out_mat             = out_mat_reg;
    assign out_singular        = out_sing_reg;
    assign out_is_identity     = out_ident_reg;
    assign out_saturated       = out_sat_reg;
endmodule

[sv/amci_ctrl.sv]
// Controller: sequences load, compose and invert over the shared datapath.
module amci_ctrl import amci_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    output logic       out_valid,
    input  logic       out_ready,
    output cmd_t       cmd,
    input  status_t    status
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOAD    = 4'd1;
    localparam logic [3:0] S_CMP     = 4'd2;
    localparam logic [3:0] S_DET     = 4'd3;
    localparam logic [3:0] S_DETCHK  = 4'd4;
    localparam logic [3:0] S_NUM     = 4'd5;
    localparam logic [3:0] S_DIVGO   = 4'd6;
    localparam logic [3:0] S_DIVWAIT = 4'd7;
    localparam logic [3:0] S_COMMIT  = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]       st_reg, st_next;
    logic [IDX_W-1:0] elem_reg, elem_next;
    logic [1:0]       ph_reg, ph_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    always_comb
    begin
        st_next   = st_reg;
        elem_next = elem_reg;
        ph_next   = ph_reg;
        cmd       = '0;
        in_ready  = (st_reg == S_IDLE);
        slot_free = !out_valid_reg || out_ready;

        case (st_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_we     = 1'b1;
                    cmd.flags_clr = 1'b1;
                    elem_next     = '0;
                    ph_next       = '0;
                    case (req_type)
                        REQ_LOAD:    st_next = S_LOAD;
                        REQ_COMPOSE: st_next = S_CMP;
                        REQ_INVERT:  st_next = S_DET;
                        default:     st_next = S_OUT;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.cur_op = CUR_LOAD_IN;
                st_next    = S_OUT;
            end
            S_CMP:
            begin
                // even elements use a/c of current, odd ones b/d
                cmd.mul_en = ph_reg inside {2'd0, 2'd1};
                cmd.mx_sel = (ph_reg == 2'd0) ? (elem_reg[0] ? IDX_B : IDX_A)
                                              : (elem_reg[0] ? IDX_D : IDX_C);
                cmd.my_sel = {elem_reg[2:1], ph_reg[0]};
                cmd.base_half = 1'b1;
                cmd.base_w    = elem_reg inside {IDX_TX, IDX_TY};
                cmd.w_sel     = elem_reg;
                ph_next       = ph_reg + 1'b1;
                case (ph_reg)
                    2'd1:    cmd.acc_op = ACC_SET;
                    2'd2:    cmd.acc_op = ACC_ADD;
                    2'd3:
                    begin
                        cmd.res_we  = 1'b1;
                        cmd.res_sel = elem_reg;
                        elem_next   = elem_reg + 1'b1;
                        if (elem_reg == IDX_TY)
                        begin
                            st_next = S_COMMIT;
                        end
                    end
                    default: cmd.acc_op = ACC_HOLD;
                endcase
            end
            S_DET:
            begin
                cmd.my_cur = 1'b1;
                cmd.mul_en = ph_reg inside {2'd0, 2'd1};
                cmd.mx_sel = (ph_reg == 2'd0) ? IDX_A : IDX_B;
                cmd.my_sel = (ph_reg == 2'd0) ? IDX_D : IDX_C;
                ph_next    = ph_reg + 1'b1;
                case (ph_reg)
                    2'd1:    cmd.acc_op = ACC_SET;
                    2'd2:    cmd.acc_op = ACC_SUB;
                    2'd3:
                    begin
                        cmd.det_we = 1'b1;
                        st_next    = S_DETCHK;
                    end
                    default: cmd.acc_op = ACC_HOLD;
                endcase
            end
            S_DETCHK:
            begin
                elem_next = '0;
                if (status.det_singular)
                begin
                    cmd.cur_op = CUR_LOAD_IDENT;
                    st_next    = S_OUT;
                end
                else
                begin
                    st_next = S_DIVGO;
                end
            end
            S_NUM:
            begin
                // tx: c*ty - d*tx, ty: b*tx - a*ty
                cmd.my_cur = 1'b1;
                cmd.mul_en = ph_reg inside {2'd0, 2'd1};
                if (elem_reg == IDX_TX)
                begin
                    cmd.mx_sel = (ph_reg == 2'd0) ? IDX_C : IDX_D;
                    cmd.my_sel = (ph_reg == 2'd0) ? IDX_TY : IDX_TX;
                end
                else
                begin
                    cmd.mx_sel = (ph_reg == 2'd0) ? IDX_B : IDX_A;
                    cmd.my_sel = (ph_reg == 2'd0) ? IDX_TX : IDX_TY;
                end
                ph_next = ph_reg + 1'b1;
                case (ph_reg)
                    2'd1:    cmd.acc_op = ACC_SET;
                    2'd2:
                    begin
                        cmd.acc_op = ACC_SUB;
                        st_next    = S_DIVGO;
                    end
                    default: cmd.acc_op = ACC_HOLD;
                endcase
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                case (elem_reg)
                    IDX_A:
                    begin
                        cmd.div_num_sel = IDX_D;
                        cmd.div_wide    = 1'b1;
                    end
                    IDX_B:
                    begin
                        cmd.div_num_sel = IDX_B;
                        cmd.div_flip    = 1'b1;
                        cmd.div_wide    = 1'b1;
                    end
                    IDX_C:
                    begin
                        cmd.div_num_sel = IDX_C;
                        cmd.div_flip    = 1'b1;
                        cmd.div_wide    = 1'b1;
                    end
                    IDX_D:
                    begin
                        cmd.div_num_sel = IDX_A;
                        cmd.div_wide    = 1'b1;
                    end
                    default:
                    begin
                        cmd.div_num_acc = 1'b1;
                    end
                endcase
                st_next = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.res_we  = 1'b1;
                    cmd.res_div = 1'b1;
                    cmd.res_sel = elem_reg;
                    elem_next   = elem_reg + 1'b1;
                    ph_next     = '0;
                    if (elem_reg == IDX_TY)
                    begin
                        st_next = S_COMMIT;
                    end
                    else if (elem_reg inside {IDX_D, IDX_TX})
                    begin
                        st_next = S_NUM;
                    end
                    else
                    begin
                        st_next = S_DIVGO;
                    end
                end
            end
            S_COMMIT:
            begin
                cmd.cur_op = CUR_LOAD_RES;
                st_next    = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_we = 1'b1;
                    st_next    = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        if (cmd.out_we)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            elem_reg      <= '0;
            ph_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            elem_reg      <= elem_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

[sv/affine_matrix_compose_invert.sv]
// Invert time is set by the 33-step restoring divider, run once per element; a quotient
// that overflows skips the steps and a singular invert skips the divider. Compose time is
// set by the one shared 32x32 multiplier (two products per element). An unused request
// type goes straight to the output.
// One request is in work at a time; the next is taken while a result waits.
// Reset (rst_n low, asynchronous): current matrix becomes identity, threshold 1.
module affine_matrix_compose_invert import amci_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    amci_cfg_if.sink    cfg,
    amci_req_if.sink    req,
    amci_rsp_if.source  rsp
);
    cmd_t    cmd;
    status_t status;
    mat_t    in_mat;
    mat_t    out_mat;
    logic    out_valid;

    // the threshold register takes a transfer in any cycle
    assign cfg.ready = 1'b1;

    // pack the request operand into one matrix word
    assign in_mat = '{a: req.in_a, b: req.in_b, c: req.in_c, d: req.in_d,
                      tx: req.in_tx, ty: req.in_ty};

    amci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .req_type  (req.req_type),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    amci_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg.valid),
        .cfg_data        (cfg.singular_threshold),
        .in_mat          (in_mat),
        .cmd             (cmd),
        .status          (status),
        .out_mat         (out_mat),
        .out_singular    (rsp.singular),
        .out_is_identity (rsp.is_identity),
        .out_saturated   (rsp.saturated)
    );

    // hold the result in the output register until the transfer
    assign rsp.valid  = out_valid;
    assign rsp.out_a  = out_mat.a;
    assign rsp.out_b  = out_mat.b;
    assign rsp.out_c  = out_mat.c;
    assign rsp.out_d  = out_mat.d;
    assign rsp.out_tx = out_mat.tx;
    assign rsp.out_ty = out_mat.ty;
endmodule

[sv/amci_checker.sv]
// Port-level checker of the affine matrix unit and its bind.
`include "affine_matrix_compose_invert_macros.svh"
module amci_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_a,
    input logic        rsp_singular,
    input logic        rsp_is_identity,
    input logic        rsp_saturated
);
    logic [2:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg + {2'b0, req_valid && req_ready} - {2'b0, rsp_valid && rsp_ready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `AMCI_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_a))
    `AMCI_ASSERT_IMP(a_sing_ident, rsp_valid && rsp_singular, rsp_is_identity && !rsp_saturated)
    `AMCI_ASSERT_IMP(a_no_orphan, rsp_valid, pend_reg != 3'd0)
    `AMCI_ASSERT_IMP(a_pend_max, req_valid && req_ready, pend_reg <= 3'd1)
endmodule

bind affine_matrix_compose_invert amci_checker u_amci_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_a           (rsp.out_a),
    .rsp_singular    (rsp.singular),
    .rsp_is_identity (rsp.is_identity),
    .rsp_saturated   (rsp.saturated)
);
